// ===== sv/sip_pkg.sv =====
// Package: shared constants, control struct and output saturation for the segment block.
`timescale 1ns / 1ps
`default_nettype none
package sip_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int OUT_W          = 32;

  localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  // Per-item flags that ride along the divider chain.
  typedef struct packed {
    logic meet;
    logic parallel;
    logic neg_x;
    logic neg_y;
  } sip_ctl_t;

  // Apply sign and saturation to a quotient magnitude.
  function automatic logic [OUT_W-1:0] sip_fix(input logic [OUT_W-1:0] q,
                                               input logic sat, input logic neg);
    logic big;
    big = sat | q[OUT_W-1];
    if (neg) begin
      sip_fix = big ? SAT_NEG : (~q + 1'b1);
    end else begin
      sip_fix = big ? SAT_POS : q;
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/sip_in_if.sv =====
// Interface: input channel carrying one pair of segments.
`timescale 1ns / 1ps
`default_nettype none
interface sip_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_start_x;
  logic signed [COORD_BITS-1:0] first_start_y;
  logic signed [COORD_BITS-1:0] first_end_x;
  logic signed [COORD_BITS-1:0] first_end_y;
  logic signed [COORD_BITS-1:0] second_start_x;
  logic signed [COORD_BITS-1:0] second_start_y;
  logic signed [COORD_BITS-1:0] second_end_x;
  logic signed [COORD_BITS-1:0] second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/sip_out_if.sv =====
// Interface: result channel carrying meet flag, parallel flag and crossing point.
`timescale 1ns / 1ps
`default_nettype none
interface sip_out_if;
  logic               valid;
  logic               ready;
  logic               segments_meet;
  logic               lines_parallel;
  logic signed [31:0] cross_x;
  logic signed [31:0] cross_y;

  modport source (
    output valid, segments_meet, lines_parallel, cross_x, cross_y,
    input  ready
  );
  modport sink (
    input  valid, segments_meet, lines_parallel, cross_x, cross_y,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/segment_intersection_point.sv =====
// Top level: segment meet test and fixed-point crossing point of the carrying lines.
//
//   channel  dir  payload
//   seg_in   in   two segments, eight signed coordinates of COORD_BITS
//   res_out  out  segments_meet, lines_parallel, cross_x, cross_y (32 bit)
//
// One item per cycle while res_out is not held; each item passes the front stages, the
// divider chain (one quotient bit per cell) and the output register.
// Reset clears all stage valid bits; payload registers are not reset.
// A held result on res_out stalls the whole pipeline, and seg_in.ready drops.
`timescale 1ns / 1ps
`default_nettype none
module segment_intersection_point
  import sip_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  sip_in_if.sink      seg_in,
  sip_out_if.source   res_out
);

  localparam int DETW  = 2 * COORD_BITS + 3;
  localparam int NUMW  = 3 * COORD_BITS + 4;
  localparam int STEPS = NUMW + FRAC_BITS;

  logic en;
  assign en = !res_out.valid || res_out.ready;
  assign seg_in.ready = en;

  logic                  v_s   [0:STEPS];
  sip_ctl_t              ctl_s [0:STEPS];
  logic [NUMW-1:0]       nx_s  [0:STEPS];
  logic [NUMW-1:0]       ny_s  [0:STEPS];
  logic [DETW-1:0]       dm_s  [0:STEPS];
  logic [DETW-1:0]       rx_s  [0:STEPS];
  logic [DETW-1:0]       ry_s  [0:STEPS];
  logic [OUT_W-1:0]      qx_s  [0:STEPS];
  logic [OUT_W-1:0]      qy_s  [0:STEPS];
  logic                  sx_s  [0:STEPS];
  logic                  sy_s  [0:STEPS];

  sip_front #(
    .COORD_BITS(COORD_BITS),
    .DETW      (DETW),
    .NUMW      (NUMW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (seg_in.valid),
    .x1       (seg_in.first_start_x),
    .y1       (seg_in.first_start_y),
    .x2       (seg_in.first_end_x),
    .y2       (seg_in.first_end_y),
    .x3       (seg_in.second_start_x),
    .y3       (seg_in.second_start_y),
    .x4       (seg_in.second_end_x),
    .y4       (seg_in.second_end_y),
    .out_valid(v_s[0]),
    .out_ctl  (ctl_s[0]),
    .num_x    (nx_s[0]),
    .num_y    (ny_s[0]),
    .det_mag  (dm_s[0])
  );

  assign rx_s[0] = '0;
  assign ry_s[0] = '0;
  assign qx_s[0] = '0;
  assign qy_s[0] = '0;
  assign sx_s[0] = 1'b0;
  assign sy_s[0] = 1'b0;

  generate
    for (genvar i = 0; i < STEPS; i++) begin : g_chain
      sip_cell #(
        .DETW(DETW),
        .NUMW(NUMW),
        .STEP(i)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .in_valid (v_s[i]),
        .in_ctl   (ctl_s[i]),
        .in_num_x (nx_s[i]),
        .in_num_y (ny_s[i]),
        .in_dm    (dm_s[i]),
        .in_rem_x (rx_s[i]),
        .in_rem_y (ry_s[i]),
        .in_q_x   (qx_s[i]),
        .in_q_y   (qy_s[i]),
        .in_sat_x (sx_s[i]),
        .in_sat_y (sy_s[i]),
        .out_valid(v_s[i+1]),
        .out_ctl  (ctl_s[i+1]),
        .out_num_x(nx_s[i+1]),
        .out_num_y(ny_s[i+1]),
        .out_dm   (dm_s[i+1]),
        .out_rem_x(rx_s[i+1]),
        .out_rem_y(ry_s[i+1]),
        .out_q_x  (qx_s[i+1]),
        .out_q_y  (qy_s[i+1]),
        .out_sat_x(sx_s[i+1]),
        .out_sat_y(sy_s[i+1])
      );
    end
  endgenerate

  // output register
  sip_ctl_t last_ctl;
  assign last_ctl = ctl_s[STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_out.valid <= 1'b0;
    end else if (en) begin
      res_out.valid <= v_s[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_out.segments_meet  <= last_ctl.meet;
      res_out.lines_parallel <= last_ctl.parallel;
      res_out.cross_x <= last_ctl.parallel ? '0 :
                         sip_fix(qx_s[STEPS], sx_s[STEPS], last_ctl.neg_x);
      res_out.cross_y <= last_ctl.parallel ? '0 :
                         sip_fix(qy_s[STEPS], sy_s[STEPS], last_ctl.neg_y);
    end
  end

`ifndef SYNTHESIS
  a_par_zero: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res_out.lines_parallel |-> res_out.cross_x == 0 && res_out.cross_y == 0)
    else $error("parallel result with nonzero point");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && !res_out.ready |-> !seg_in.ready)
    else $error("input taken while result is held");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_out.valid && !v_s[0])
    else $error("pipeline not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v_s[STEPS]) && $stable(v_s[0]))
    else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire

// ===== sv/sip_front.sv =====
// Front pipeline: orientation tests, line coefficients, determinant and numerators.
`timescale 1ns / 1ps
`default_nettype none
module sip_front
  import sip_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int DETW       = 2 * COORD_BITS + 3,
  parameter int NUMW       = 3 * COORD_BITS + 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic signed [COORD_BITS-1:0] x1,
  input  wire logic signed [COORD_BITS-1:0] y1,
  input  wire logic signed [COORD_BITS-1:0] x2,
  input  wire logic signed [COORD_BITS-1:0] y2,
  input  wire logic signed [COORD_BITS-1:0] x3,
  input  wire logic signed [COORD_BITS-1:0] y3,
  input  wire logic signed [COORD_BITS-1:0] x4,
  input  wire logic signed [COORD_BITS-1:0] y4,
  output logic                              out_valid,
  output sip_ctl_t                          out_ctl,
  output logic [NUMW-1:0]                   num_x,
  output logic [NUMW-1:0]                   num_y,
  output logic [DETW-1:0]                   det_mag
);

  localparam int N   = COORD_BITS;
  localparam int DW  = N + 1;
  localparam int PW  = 2 * DW;
  localparam int OW  = PW + 1;
  localparam int XW  = DW + N;
  localparam int EW  = XW + 1;
  localparam int MW  = EW + DW;

  // stage a: differences and collinear overlap test
  logic                 va;
  logic signed [DW-1:0] a_a, a_b, a_c, a_d;
  logic signed [N-1:0]  a_x1, a_y1, a_x3, a_y3;
  logic signed [DW-1:0] a_d31x, a_d31y, a_d41x, a_d41y;
  logic signed [DW-1:0] a_d13x, a_d13y, a_d23x, a_d23y;
  logic                 a_colm;

  logic                 le12, le34;
  logic signed [N-1:0]  lo1x, lo1y, hi1x, hi1y, lo2x, lo2y, hi2x, hi2y;
  logic                 col_meet;

  always_comb begin
    le12 = (x1 < x2) || (x1 == x2 && y1 <= y2);
    le34 = (x3 < x4) || (x3 == x4 && y3 <= y4);
    lo1x = le12 ? x1 : x2;
    lo1y = le12 ? y1 : y2;
    hi1x = le12 ? x2 : x1;
    hi1y = le12 ? y2 : y1;
    lo2x = le34 ? x3 : x4;
    lo2y = le34 ? y3 : y4;
    hi2x = le34 ? x4 : x3;
    hi2y = le34 ? y4 : y3;
    col_meet = ((lo2x < hi1x) || (lo2x == hi1x && lo2y <= hi1y)) &&
               ((lo1x < hi2x) || (lo1x == hi2x && lo1y <= hi2y));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_a    <= DW'(y2) - DW'(y1);
      a_b    <= DW'(x1) - DW'(x2);
      a_c    <= DW'(y4) - DW'(y3);
      a_d    <= DW'(x3) - DW'(x4);
      a_x1   <= x1;
      a_y1   <= y1;
      a_x3   <= x3;
      a_y3   <= y3;
      a_d31x <= DW'(x3) - DW'(x1);
      a_d31y <= DW'(y3) - DW'(y1);
      a_d41x <= DW'(x4) - DW'(x1);
      a_d41y <= DW'(y4) - DW'(y1);
      a_d13x <= DW'(x1) - DW'(x3);
      a_d13y <= DW'(y1) - DW'(y3);
      a_d23x <= DW'(x2) - DW'(x3);
      a_d23y <= DW'(y2) - DW'(y3);
      a_colm <= col_meet;
    end
  end

  // stage b: all products of narrow terms
  logic                 vb;
  logic signed [PW-1:0] b_p1, b_p2, b_p3, b_p4, b_p5, b_p6, b_p7, b_p8;
  logic signed [XW-1:0] b_ax1, b_by1, b_cx3, b_dy3;
  logic signed [PW-1:0] b_ad, b_bc;
  logic signed [DW-1:0] b_a, b_b, b_c, b_d;
  logic                 b_colm;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // orientation o = -(p_odd + p_even)
      b_p1   <= PW'(a_b) * PW'(a_d31y);
      b_p2   <= PW'(a_a) * PW'(a_d31x);
      b_p3   <= PW'(a_b) * PW'(a_d41y);
      b_p4   <= PW'(a_a) * PW'(a_d41x);
      b_p5   <= PW'(a_d) * PW'(a_d13y);
      b_p6   <= PW'(a_c) * PW'(a_d13x);
      b_p7   <= PW'(a_d) * PW'(a_d23y);
      b_p8   <= PW'(a_c) * PW'(a_d23x);
      b_ax1  <= XW'(a_a) * XW'(a_x1);
      b_by1  <= XW'(a_b) * XW'(a_y1);
      b_cx3  <= XW'(a_c) * XW'(a_x3);
      b_dy3  <= XW'(a_d) * XW'(a_y3);
      b_ad   <= PW'(a_a) * PW'(a_d);
      b_bc   <= PW'(a_b) * PW'(a_c);
      b_a    <= a_a;
      b_b    <= a_b;
      b_c    <= a_c;
      b_d    <= a_d;
      b_colm <= a_colm;
    end
  end

  // stage c: orientation signs, meet decision, E, F, det
  logic                   vc;
  logic signed [EW-1:0]   c_e, c_f;
  logic signed [DETW-1:0] c_det;
  logic signed [DW-1:0]   c_a, c_b, c_c, c_d;
  logic                   c_meet;

  logic signed [OW-1:0] s1, s2, s3, s4;
  logic                 z1, z2, z3, z4;
  logic                 s12_zero, s34_zero, s12_le, s34_le, meet;

  always_comb begin
    s1 = OW'(b_p1) + OW'(b_p2);
    s2 = OW'(b_p3) + OW'(b_p4);
    s3 = OW'(b_p5) + OW'(b_p6);
    s4 = OW'(b_p7) + OW'(b_p8);
    z1 = (s1 == '0);
    z2 = (s2 == '0);
    z3 = (s3 == '0);
    z4 = (s4 == '0);
    s12_zero = z1 | z2;
    s34_zero = z3 | z4;
    // product of two nonzero signs is <= 0 when they differ
    s12_le = s12_zero | (s1[OW-1] != s2[OW-1]);
    s34_le = s34_zero | (s3[OW-1] != s4[OW-1]);
    meet = (s12_zero && s34_zero) ? b_colm : (s12_le && s34_le);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_e    <= EW'(b_ax1) + EW'(b_by1);
      c_f    <= EW'(b_cx3) + EW'(b_dy3);
      c_det  <= DETW'(b_ad) - DETW'(b_bc);
      c_a    <= b_a;
      c_b    <= b_b;
      c_c    <= b_c;
      c_d    <= b_d;
      c_meet <= meet;
    end
  end

  // stage d: numerator products
  logic                   vd;
  logic signed [MW-1:0]   d_ed, d_bf, d_af, d_ec;
  logic signed [DETW-1:0] d_det;
  logic                   d_meet, d_par;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_ed   <= MW'(c_e) * MW'(c_d);
      d_bf   <= MW'(c_b) * MW'(c_f);
      d_af   <= MW'(c_a) * MW'(c_f);
      d_ec   <= MW'(c_e) * MW'(c_c);
      d_det  <= c_det;
      d_meet <= c_meet;
      d_par  <= (c_det == '0);
    end
  end

  // stage e: numerators, magnitudes and quotient signs
  logic signed [NUMW-1:0] nx, ny;
  logic                   det_neg;

  always_comb begin
    nx      = NUMW'(d_ed) - NUMW'(d_bf);
    ny      = NUMW'(d_af) - NUMW'(d_ec);
    det_neg = d_det[DETW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_x            <= nx[NUMW-1] ? (~nx + 1'b1) : nx;
      num_y            <= ny[NUMW-1] ? (~ny + 1'b1) : ny;
      det_mag          <= det_neg ? (~d_det + 1'b1) : d_det;
      out_ctl.meet     <= d_meet;
      out_ctl.parallel <= d_par;
      out_ctl.neg_x    <= nx[NUMW-1] ^ det_neg;
      out_ctl.neg_y    <= ny[NUMW-1] ^ det_neg;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sip_cell.sv =====
// Divider cell: one restoring-division step for both quotients, then hand to the next cell.
`timescale 1ns / 1ps
`default_nettype none
module sip_cell
  import sip_pkg::*;
#(
  parameter int DETW = 35,
  parameter int NUMW = 52,
  parameter int STEP = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire sip_ctl_t         in_ctl,
  input  wire logic [NUMW-1:0]  in_num_x,
  input  wire logic [NUMW-1:0]  in_num_y,
  input  wire logic [DETW-1:0]  in_dm,
  input  wire logic [DETW-1:0]  in_rem_x,
  input  wire logic [DETW-1:0]  in_rem_y,
  input  wire logic [OUT_W-1:0] in_q_x,
  input  wire logic [OUT_W-1:0] in_q_y,
  input  wire logic             in_sat_x,
  input  wire logic             in_sat_y,
  output logic                  out_valid,
  output sip_ctl_t              out_ctl,
  output logic [NUMW-1:0]       out_num_x,
  output logic [NUMW-1:0]       out_num_y,
  output logic [DETW-1:0]       out_dm,
  output logic [DETW-1:0]       out_rem_x,
  output logic [DETW-1:0]       out_rem_y,
  output logic [OUT_W-1:0]      out_q_x,
  output logic [OUT_W-1:0]      out_q_y,
  output logic                  out_sat_x,
  output logic                  out_sat_y
);

  logic            bit_x, bit_y;
  logic [DETW:0]   sh_x, sh_y, df_x, df_y;
  logic            ge_x, ge_y;

  // dividend bits past the numerator are the fraction zeros
  generate
    if (STEP < NUMW) begin : g_num
      assign bit_x = in_num_x[NUMW-1-STEP];
      assign bit_y = in_num_y[NUMW-1-STEP];
    end else begin : g_frac
      assign bit_x = 1'b0;
      assign bit_y = 1'b0;
    end
  endgenerate

  always_comb begin
    sh_x = {in_rem_x, bit_x};
    sh_y = {in_rem_y, bit_y};
    ge_x = (sh_x >= {1'b0, in_dm});
    ge_y = (sh_y >= {1'b0, in_dm});
    df_x = sh_x - {1'b0, in_dm};
    df_y = sh_y - {1'b0, in_dm};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctl   <= in_ctl;
      out_num_x <= in_num_x;
      out_num_y <= in_num_y;
      out_dm    <= in_dm;
      out_rem_x <= ge_x ? df_x[DETW-1:0] : sh_x[DETW-1:0];
      out_rem_y <= ge_y ? df_y[DETW-1:0] : sh_y[DETW-1:0];
      out_q_x   <= {in_q_x[OUT_W-2:0], ge_x};
      out_q_y   <= {in_q_y[OUT_W-2:0], ge_y};
      // latch overflow once a bit falls off the top
      out_sat_x <= in_sat_x | in_q_x[OUT_W-1];
      out_sat_y <= in_sat_y | in_q_y[OUT_W-1];
    end
  end

endmodule
`default_nettype wire

// ===== dv/segment_intersection_point_test.sv =====
// Testbench: streams segment pairs through the block and checks all result fields.
`timescale 1ns / 1ps
module segment_intersection_point_test
  import sip_pkg::*;
;

  typedef struct packed {
    logic signed [15:0] x1, y1, x2, y2, x3, y3, x4, y4;
  } seg_pair_t;

  typedef struct packed {
    logic               meet;
    logic               parallel;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } crossing_t;

  logic clk;
  logic rst;

  sip_in_if #(.COORD_BITS(16)) seg_if ();
  sip_out_if                   res_if ();

  segment_intersection_point u_top (
    .clk(clk),
    .rst(rst),
    .seg_in(seg_if),
    .res_out(res_if)
  );

  seg_pair_t pending_pairs[$];
  crossing_t expected_crossings[$];
  int        send_idle_pct;
  int        recv_stall_pct;
  int        errors;
  int        long_hold_cycles;
  logic      long_hold_req;

  // Sign of the cross product (b - a) x (c - a).
  function automatic int turn(longint ax, longint ay, longint bx, longint by,
                              longint cx, longint cy);
    longint v;
    v = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  function automatic logic lex_le(longint ax, longint ay, longint bx, longint by);
    return (ax < bx) || (ax == bx && ay <= by);
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [127:0] q);
    if (q > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (q < -128'sh80000000) return 32'sh80000000;
    return q[31:0];
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t s);
    longint x1, y1, x2, y2, x3, y3, x4, y4;
    longint lx1, ly1, lx2, ly2, lx3, ly3, lx4, ly4;
    longint a, b, c, d, e, f, det;
    int s12, s34;
    logic signed [127:0] aw, bw, cw, dw, ew, fw, den;
    crossing_t r;
    x1 = longint'(s.x1); y1 = longint'(s.y1); x2 = longint'(s.x2); y2 = longint'(s.y2);
    x3 = longint'(s.x3); y3 = longint'(s.y3); x4 = longint'(s.x4); y4 = longint'(s.y4);
    s12 = turn(x1, y1, x2, y2, x3, y3) * turn(x1, y1, x2, y2, x4, y4);
    s34 = turn(x3, y3, x4, y4, x1, y1) * turn(x3, y3, x4, y4, x2, y2);
    if (s12 == 0 && s34 == 0) begin
      // collinear: order each segment's ends, then test interval overlap
      if (lex_le(x1, y1, x2, y2)) begin
        lx1 = x1; ly1 = y1; lx2 = x2; ly2 = y2;
      end else begin
        lx1 = x2; ly1 = y2; lx2 = x1; ly2 = y1;
      end
      if (lex_le(x3, y3, x4, y4)) begin
        lx3 = x3; ly3 = y3; lx4 = x4; ly4 = y4;
      end else begin
        lx3 = x4; ly3 = y4; lx4 = x3; ly4 = y3;
      end
      r.meet = lex_le(lx3, ly3, lx2, ly2) && lex_le(lx1, ly1, lx4, ly4);
    end else begin
      r.meet = s12 <= 0 && s34 <= 0;
    end
    a = y2 - y1; b = x1 - x2; e = a * x1 + b * y1;
    c = y4 - y3; d = x3 - x4; f = c * x3 + d * y3;
    det = a * d - b * c;
    if (det == 0) begin
      r.parallel = 1'b1;
      r.px = '0;
      r.py = '0;
    end else begin
      aw = 128'(a); bw = 128'(b); cw = 128'(c); dw = 128'(d);
      ew = 128'(e); fw = 128'(f); den = 128'(det);
      r.parallel = 1'b0;
      r.px = clamp32(((ew * dw - bw * fw) <<< FRAC_BITS_DEF) / den);
      r.py = clamp32(((aw * fw - ew * cw) <<< FRAC_BITS_DEF) / den);
    end
    return r;
  endfunction

  function automatic seg_pair_t mk_pair(int x1, int y1, int x2, int y2,
                                        int x3, int y3, int x4, int y4);
    seg_pair_t s;
    s.x1 = 16'(x1); s.y1 = 16'(y1); s.x2 = 16'(x2); s.y2 = 16'(y2);
    s.x3 = 16'(x3); s.y3 = 16'(y3); s.x4 = 16'(x4); s.y4 = 16'(y4);
    return s;
  endfunction

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t s;
    int bx, by, dx, dy, t1, t2, t3, t4;
    case ($urandom_range(3))
      0: s = {$urandom, $urandom, $urandom, $urandom};
      1: s = mk_pair(pick(-8, 8), pick(-8, 8), pick(-8, 8), pick(-8, 8),
                     pick(-8, 8), pick(-8, 8), pick(-8, 8), pick(-8, 8));
      2: begin
        // all four points on one line
        bx = pick(-1000, 1000); by = pick(-1000, 1000);
        dx = pick(-3, 3); dy = pick(-3, 3);
        t1 = pick(-20, 20); t2 = pick(-20, 20); t3 = pick(-20, 20); t4 = pick(-20, 20);
        s = mk_pair(bx + t1 * dx, by + t1 * dy, bx + t2 * dx, by + t2 * dy,
                    bx + t3 * dx, by + t3 * dy, bx + t4 * dx, by + t4 * dy);
      end
      default: begin
        // nearly parallel lines, far crossing point
        dx = pick(-20000, 20000); dy = pick(-20000, 20000);
        bx = pick(-1000, 1000); by = pick(-1000, 1000);
        s = mk_pair(0, 0, dx, dy, bx, by, bx + dx, by + dy + pick(-1, 1));
      end
    endcase
    return s;
  endfunction

  // Append one pair to the pending queue.
  task automatic add_pair(seg_pair_t p);
    pending_pairs = {pending_pairs, p};
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sender: offer the next pending pair, record its expectation on transfer.
  always @(posedge clk) begin
    if (rst) begin
      seg_if.valid <= 1'b0;
    end else begin
      if (seg_if.valid && seg_if.ready) begin
        expected_crossings = {expected_crossings, predict_crossing({seg_if.first_start_x,
          seg_if.first_start_y, seg_if.first_end_x, seg_if.first_end_y,
          seg_if.second_start_x, seg_if.second_start_y, seg_if.second_end_x,
          seg_if.second_end_y})};
      end
      if (!seg_if.valid || seg_if.ready) begin
        if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          seg_pair_t p;
          p = pending_pairs.pop_front();
          seg_if.valid          <= 1'b1;
          seg_if.first_start_x  <= p.x1;
          seg_if.first_start_y  <= p.y1;
          seg_if.first_end_x    <= p.x2;
          seg_if.first_end_y    <= p.y2;
          seg_if.second_start_x <= p.x3;
          seg_if.second_start_y <= p.y3;
          seg_if.second_end_x   <= p.x4;
          seg_if.second_end_y   <= p.y4;
        end else begin
          seg_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk) begin
    if (rst) begin
      long_hold_cycles <= 0;
    end else if (long_hold_req && long_hold_cycles == 0) begin
      long_hold_cycles <= 400;
    end else if (long_hold_cycles > 1) begin
      long_hold_cycles <= long_hold_cycles - 1;
    end
  end

  // Receiver: check each transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_crossings.size() == 0) begin
          $error("unexpected result: meet=%0b parallel=%0b x=%0d y=%0d",
                 res_if.segments_meet, res_if.lines_parallel, res_if.cross_x,
                 res_if.cross_y);
          errors++;
        end else begin
          crossing_t w;
          w = expected_crossings.pop_front();
          if (res_if.segments_meet !== w.meet) begin
            $error("segments_meet: expected %0b, got %0b", w.meet, res_if.segments_meet);
            errors++;
          end
          if (res_if.lines_parallel !== w.parallel) begin
            $error("lines_parallel: expected %0b, got %0b", w.parallel,
                   res_if.lines_parallel);
            errors++;
          end
          if (res_if.cross_x !== w.px) begin
            $error("cross_x: expected %0d, got %0d", w.px, res_if.cross_x);
            errors++;
          end
          if (res_if.cross_y !== w.py) begin
            $error("cross_y: expected %0d, got %0d", w.py, res_if.cross_y);
            errors++;
          end
        end
      end
      res_if.ready <= !(long_hold_req && long_hold_cycles != 1) &&
                      ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic drain();
    wait (pending_pairs.size() == 0);
    @(posedge clk);
    while (seg_if.valid || expected_crossings.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int n, int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) add_pair(random_pair());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_req = 1'b0;
    seg_if.valid = 1'b0;
    seg_if.first_start_x = '0;
    seg_if.first_start_y = '0;
    seg_if.first_end_x = '0;
    seg_if.first_end_y = '0;
    seg_if.second_start_x = '0;
    seg_if.second_start_y = '0;
    seg_if.second_end_x = '0;
    seg_if.second_end_y = '0;
    res_if.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    add_pair(mk_pair(0, 0, 4, 4, 0, 4, 4, 0));          // plain crossing
    add_pair(mk_pair(0, 0, 4, 4, 5, 0, 9, 1));          // miss
    add_pair(mk_pair(0, 0, 4, 0, 4, 0, 4, 5));          // touching ends
    add_pair(mk_pair(0, 0, 4, 0, 2, 0, 2, 3));          // end on interior
    add_pair(mk_pair(0, 0, 4, 0, 0, 1, 4, 1));          // parallel apart
    add_pair(mk_pair(0, 0, 4, 4, 2, 2, 6, 6));          // collinear overlap
    add_pair(mk_pair(4, 4, 0, 0, 6, 6, 2, 2));          // reversed ends
    add_pair(mk_pair(0, 0, 2, 2, 3, 3, 5, 5));          // collinear gap
    add_pair(mk_pair(0, 0, 2, 2, 2, 2, 5, 5));          // collinear touch
    add_pair(mk_pair(3, 0, 3, 4, 3, 5, 3, 9));          // vertical gap
    add_pair(mk_pair(1, 1, 1, 1, 0, 0, 2, 2));          // zero length on line
    add_pair(mk_pair(1, 1, 1, 1, 1, 1, 1, 1));          // both points
    add_pair(mk_pair(0, 0, 1, 3, 0, 1, 1, 4));          // offset parallel
    add_pair(mk_pair(0, 0, 32767, 32766, 0, 1, 32767, 32767)); // parallel lines at full range
    add_pair(mk_pair(-32768, -32768, 32767, 32767,
                     -32768, 32767, 32767, -32768));
    add_pair(mk_pair(32767, 32767, 32767, 32767,
                     -32768, -32768, -32768, -32768));
    add_pair(mk_pair(-32768, 0, 32767, 1, -32768, 1, 32767, 0));
    add_pair(mk_pair(0, 0, 3, 1, 0, 1, 3, -1));         // fractional point
    add_pair(mk_pair(0, 0, -3, 1, 0, 1, -3, -1));
    drain();

    run_phase(130, 0, 0);
    run_phase(130, 59, 0);
    run_phase(130, 0, 59);
    run_phase(130, 27, 27);
    long_hold_req = 1'b1;
    run_phase(130, 0, 0);
    long_hold_req = 1'b0;

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
